FILE: rtl/pmu_pkg.sv
// pmu_pkg: shared types, register indexes, channel codes and flag bits
// for the power rail monitor; no dependencies
package pmu_pkg;

  localparam int VAL_W  = 16;
  localparam int SMP_W  = 10;
  localparam int CH_W   = 3;
  localparam int FLAG_W = 8;
  localparam int ILIM_W = 18;
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 18;
  localparam int NUM_SLOT = 6;

  // register indexes
  localparam logic [CFG_AW-1:0] REG_VGAIN  = 3'd0;
  localparam logic [CFG_AW-1:0] REG_IGAIN  = 3'd1;
  localparam logic [CFG_AW-1:0] REG_VLO    = 3'd2;
  localparam logic [CFG_AW-1:0] REG_VHI    = 3'd3;
  localparam logic [CFG_AW-1:0] REG_ILIM   = 3'd4;
  localparam logic [CFG_AW-1:0] REG_OTCUR  = 3'd5;
  localparam logic [CFG_AW-1:0] REG_FMASK  = 3'd6;
  localparam logic [CFG_AW-1:0] REG_CHKEN  = 3'd7;

  // channel codes
  localparam logic [CH_W-1:0] CH_TEMP  = 3'd0;
  localparam logic [CH_W-1:0] CH_VIN   = 3'd1;
  localparam logic [CH_W-1:0] CH_VOUT  = 3'd2;
  localparam logic [CH_W-1:0] CH_MOTOR = 3'd3;
  localparam logic [CH_W-1:0] CH_VDD   = 3'd4;
  localparam logic [CH_W-1:0] CH_LOAD2 = 3'd5;
  localparam logic [CH_W-1:0] CH_LOAD1 = 3'd6;
  localparam logic [CH_W-1:0] CH_NONE  = 3'd7;

  // fault flag bits
  localparam logic [FLAG_W-1:0] F_UNDER_V   = 8'h01;
  localparam logic [FLAG_W-1:0] F_OVER_V    = 8'h02;
  localparam logic [FLAG_W-1:0] F_OVER_I    = 8'h04;
  localparam logic [FLAG_W-1:0] F_MOTOR_UV  = 8'h08;
  localparam logic [FLAG_W-1:0] F_MOTOR_OL  = 8'h10;
  localparam logic [FLAG_W-1:0] F_LOAD1_OFF = 8'h20;
  localparam logic [FLAG_W-1:0] F_LOAD2_OFF = 8'h40;
  localparam logic [FLAG_W-1:0] F_SHUTDOWN  = 8'h80;

  typedef struct packed {
    logic [VAL_W-1:0]  voltage_gain;
    logic [VAL_W-1:0]  current_gain;
    logic [VAL_W-1:0]  voltage_low_limit;
    logic [VAL_W-1:0]  voltage_high_limit;
    logic [ILIM_W-1:0] total_current_limit;
    logic [VAL_W-1:0]  overtemp_current;
    logic [FLAG_W-1:0] fatal_mask;
    logic              checks_enable;
  } cfg_t;

  // one classified beat between front and back
  typedef struct packed {
    logic [CH_W-1:0]  channel;
    logic [VAL_W-1:0] value;
  } q_entry_t;

  function automatic logic [FLAG_W-1:0] raise_flag(input logic [FLAG_W-1:0] f,
                                                    input logic [FLAG_W-1:0] bits,
                                                    input logic [FLAG_W-1:0] mask);
    logic [FLAG_W-1:0] r;
    r = f | bits;
    if ((bits & mask) != '0) r = r | F_SHUTDOWN;
    return r;
  endfunction

endpackage

FILE: rtl/power_rail_monitor_unit.sv
// power_rail_monitor_unit: top level, configuration registers and the
// front/back split; depends on pmu_pkg, pmu_front, pmu_back
//
// usage
//  - input channel: one beat per converter sample, in_tuser carries the
//    channel code, in_tdata the raw 10-bit sample
//  - output channel: one beat per input beat, in order, carrying the new
//    averaged value (raw value for temperature), the latched fault flags
//    and the shutdown bit
//  - configuration: cfg_we with cfg_addr/cfg_wdata, to be written by the user only
//    while idle; the block itself does not enforce this
//  - temperature and unused beats go from the queue to the output register; averaged
//    channels pass the window update and the serial restoring divider (one quotient
//    bit per cycle); the back end takes a new beat only after committing the last one
//  - a two-beat queue sits between the scaler and the averaging back end,
//    so input beats are taken while the back end or the receiver stalls, until the queue fills
//  - a stalled receiver holds the output register; the back end finishes
//    the next beat and waits before committing it
//  - reset: synchronous, clears the windows (by fill count), flags,
//    counters and loads the register defaults
module power_rail_monitor_unit #(
  parameter int WINDOW_LEN       = 16,
  parameter int MOTOR_TRIP_COUNT = 16,
  parameter int LOAD_TRIP_COUNT  = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // sample[9:0]
  input  logic [2:0]  in_tuser,   // channel[2:0]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // channel_value[15:0], fault_flags[23:16], shut_down[24]
  input  logic        cfg_we,
  input  logic [pmu_pkg::CFG_AW-1:0] cfg_addr,
  input  logic [pmu_pkg::CFG_DW-1:0] cfg_wdata
);

  pmu_pkg::cfg_t     cfg_r;
  logic              q_valid;
  logic              q_pop;
  pmu_pkg::q_entry_t q_data;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.voltage_gain        <= 16'd256;
      cfg_r.current_gain        <= 16'd256;
      cfg_r.voltage_low_limit   <= 16'd0;
      cfg_r.voltage_high_limit  <= 16'hFFFF;
      cfg_r.total_current_limit <= 18'd262140;
      cfg_r.overtemp_current    <= 16'hFFFF;
      cfg_r.fatal_mask          <= 8'd0;
      cfg_r.checks_enable       <= 1'b0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        pmu_pkg::REG_VGAIN: cfg_r.voltage_gain        <= cfg_wdata[15:0];
        pmu_pkg::REG_IGAIN: cfg_r.current_gain        <= cfg_wdata[15:0];
        pmu_pkg::REG_VLO:   cfg_r.voltage_low_limit   <= cfg_wdata[15:0];
        pmu_pkg::REG_VHI:   cfg_r.voltage_high_limit  <= cfg_wdata[15:0];
        pmu_pkg::REG_ILIM:  cfg_r.total_current_limit <= cfg_wdata[17:0];
        pmu_pkg::REG_OTCUR: cfg_r.overtemp_current    <= cfg_wdata[15:0];
        pmu_pkg::REG_FMASK: cfg_r.fatal_mask          <= cfg_wdata[7:0];
        pmu_pkg::REG_CHKEN: cfg_r.checks_enable       <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // scaler and queue
  pmu_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .in_valid   (in_tvalid),
    .in_ready   (in_tready),
    .in_channel (in_tuser),
    .in_sample  (in_tdata[9:0]),
    .q_valid    (q_valid),
    .q_data     (q_data),
    .q_pop      (q_pop)
  );

  // averaging, divide, checks and output register
  pmu_back #(
    .WINDOW_LEN       (WINDOW_LEN),
    .MOTOR_TRIP_COUNT (MOTOR_TRIP_COUNT),
    .LOAD_TRIP_COUNT  (LOAD_TRIP_COUNT)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_data    (q_data),
    .q_pop     (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

FILE: rtl/pmu_front.sv
// pmu_front: accepts sample beats, applies the gain with saturation and
// queues classified beats for the back end; depends on pmu_pkg
module pmu_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  pmu_pkg::cfg_t             cfg,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [pmu_pkg::CH_W-1:0]  in_channel,
  input  logic [pmu_pkg::SMP_W-1:0] in_sample,
  output logic                      q_valid,
  output pmu_pkg::q_entry_t         q_data,
  input  logic                      q_pop
);

  pmu_pkg::q_entry_t q_mem_r [2];
  logic       wr_ptr_r, rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push;
  logic [pmu_pkg::VAL_W-1:0] gain;
  logic [pmu_pkg::SMP_W+pmu_pkg::VAL_W-1:0] prod;
  logic [pmu_pkg::SMP_W+pmu_pkg::VAL_W-9:0] shifted;
  pmu_pkg::q_entry_t entry;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_data   = q_mem_r[rd_ptr_r];

  always_comb begin
    gain = (in_channel == pmu_pkg::CH_VIN || in_channel == pmu_pkg::CH_VOUT) ?
           cfg.voltage_gain : cfg.current_gain;
    prod = in_sample * gain;
    shifted = prod[pmu_pkg::SMP_W+pmu_pkg::VAL_W-1:8];
    entry.channel = in_channel;
    case (in_channel)
      pmu_pkg::CH_TEMP: entry.value = {6'd0, in_sample};
      pmu_pkg::CH_NONE: entry.value = '0;
      default: begin
        // truncated 8.8 product, saturated to 16 bits
        if (shifted[17:16] != 2'd0) entry.value = '1;
        else entry.value = shifted[15:0];
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (push) q_mem_r[wr_ptr_r] <= entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= ~wr_ptr_r;
      if (q_pop) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, q_pop};
    end
  end

  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> cnt_r != 2'd0) else $error("pop from empty queue");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3) else $error("queue count out of range");
  a_push_count: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !q_pop && cnt_r == 2'd1) |=> cnt_r == 2'd2) else $error("queue count lost push");

endmodule

FILE: rtl/pmu_back.sv
// pmu_back: moving average windows, serial divider, fault checks and
// the output register; depends on pmu_pkg
module pmu_back #(
  parameter int WINDOW_LEN       = 16,
  parameter int MOTOR_TRIP_COUNT = 16,
  parameter int LOAD_TRIP_COUNT  = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pmu_pkg::cfg_t     cfg,
  input  logic              q_valid,
  input  pmu_pkg::q_entry_t q_data,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [31:0]       out_data
);

  localparam int POS_W  = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
  localparam int FILL_W = $clog2(WINDOW_LEN + 1);
  localparam int SUM_W  = pmu_pkg::VAL_W + $clog2(WINDOW_LEN);
  localparam int DEPTH  = pmu_pkg::NUM_SLOT * WINDOW_LEN;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(SUM_W + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_UPD  = 3'd1;
  localparam logic [2:0] S_DIV  = 3'd2;
  localparam logic [2:0] S_FIN  = 3'd3;

  logic [pmu_pkg::VAL_W-1:0] win_mem [DEPTH];
  logic [pmu_pkg::VAL_W-1:0] rd_data_r;

  logic [2:0]   state_r;
  logic [pmu_pkg::CH_W-1:0]  ch_r;
  logic [pmu_pkg::VAL_W-1:0] val_r;
  logic [2:0]   slot_r;
  logic [ADDR_W-1:0] addr_r;

  logic [SUM_W-1:0]  sum_r  [pmu_pkg::NUM_SLOT];
  logic [POS_W-1:0]  pos_r  [pmu_pkg::NUM_SLOT];
  logic [FILL_W-1:0] fill_r [pmu_pkg::NUM_SLOT];
  logic [pmu_pkg::VAL_W-1:0] cur_avg_r [4];

  logic [SUM_W-1:0]  dvd_r;
  logic [FILL_W-1:0] dvs_r;
  logic [FILL_W-1:0] rem_r;
  logic [CNT_W-1:0]  cnt_r;
  logic [pmu_pkg::VAL_W-1:0] avg_r;

  logic [pmu_pkg::FLAG_W-1:0] flags_r, flags_nxt;
  logic [7:0] motor_cnt_r, motor_cnt_nxt;
  logic [7:0] load1_cnt_r, load1_cnt_nxt;
  logic [7:0] load2_cnt_r, load2_cnt_nxt;

  logic        out_valid_r;
  logic [31:0] out_data_r;

  logic [2:0]        q_slot;
  logic [ADDR_W-1:0] q_addr;
  logic              avg_load;
  logic              fire;
  logic              fill_full;
  logic [pmu_pkg::VAL_W-1:0] old_val;
  logic [SUM_W-1:0]  new_sum;
  logic [FILL_W-1:0] new_fill;
  logic [POS_W-1:0]  new_pos;
  logic [FILL_W:0]   trial;

  assign q_slot  = q_data.channel - 3'd1;
  assign q_addr  = ADDR_W'(q_slot * WINDOW_LEN) + ADDR_W'(pos_r[q_slot]);
  assign q_pop   = (state_r == S_IDLE) && q_valid;
  // first finish cycle of an averaged beat only loads the quotient
  assign avg_load = (cnt_r == '0) && ch_r != pmu_pkg::CH_TEMP && ch_r != pmu_pkg::CH_NONE;
  assign fire    = (state_r == S_FIN) && !avg_load && (!out_valid_r || out_ready);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // entry at the write position is unwritten until the window has filled
  assign fill_full = (fill_r[slot_r] == FILL_W'(WINDOW_LEN));
  assign old_val   = fill_full ? rd_data_r : '0;
  assign new_sum   = sum_r[slot_r] - SUM_W'(old_val) + SUM_W'(val_r);
  assign new_fill  = fill_full ? fill_r[slot_r] : fill_r[slot_r] + 1'b1;
  assign new_pos   = (pos_r[slot_r] == POS_W'(WINDOW_LEN - 1)) ? '0 : pos_r[slot_r] + 1'b1;
  assign trial     = {rem_r, dvd_r[SUM_W-1]};

  always_ff @(posedge clk) begin
    if (q_pop) rd_data_r <= win_mem[q_addr];
    if (state_r == S_UPD) win_mem[addr_r] <= val_r;
  end

  // fault checks on the finished average
  always_comb begin
    logic [pmu_pkg::ILIM_W-1:0] total;
    logic [pmu_pkg::VAL_W-1:0] a [4];
    logic act;
    flags_nxt     = flags_r;
    motor_cnt_nxt = motor_cnt_r;
    load1_cnt_nxt = load1_cnt_r;
    load2_cnt_nxt = load2_cnt_r;
    for (int i = 0; i < 4; i++) a[i] = cur_avg_r[i];
    if (ch_r >= pmu_pkg::CH_MOTOR && ch_r <= pmu_pkg::CH_LOAD1)
      a[slot_r[1:0] - 2'd2] = avg_r;
    total = pmu_pkg::ILIM_W'(a[0]) + pmu_pkg::ILIM_W'(a[1]) +
            pmu_pkg::ILIM_W'(a[2]) + pmu_pkg::ILIM_W'(a[3]);
    act = cfg.checks_enable && !flags_nxt[7];
    unique case (ch_r)
      pmu_pkg::CH_VIN: begin
        if (act && avg_r < cfg.voltage_low_limit)
          flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_UNDER_V, cfg.fatal_mask);
        act = cfg.checks_enable && !flags_nxt[7];
        if (act && avg_r > cfg.voltage_high_limit)
          flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_OVER_V, cfg.fatal_mask);
      end
      pmu_pkg::CH_VOUT: begin
        if (act) begin
          if (avg_r > cfg.voltage_high_limit)
            flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_OVER_V, cfg.fatal_mask);
          if (avg_r < cfg.voltage_low_limit && !flags_nxt[7])
            flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_MOTOR_UV, cfg.fatal_mask);
          else
            flags_nxt = flags_nxt & ~pmu_pkg::F_MOTOR_UV;
        end
      end
      pmu_pkg::CH_MOTOR, pmu_pkg::CH_VDD, pmu_pkg::CH_LOAD2, pmu_pkg::CH_LOAD1: begin
        if (act && total > cfg.total_current_limit)
          flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_OVER_I, cfg.fatal_mask);
        act = cfg.checks_enable && !flags_nxt[7];
        if (ch_r == pmu_pkg::CH_MOTOR && act) begin
          if (avg_r > cfg.overtemp_current) begin
            if (motor_cnt_nxt < 8'(MOTOR_TRIP_COUNT)) motor_cnt_nxt = motor_cnt_nxt + 8'd1;
            if (motor_cnt_nxt == 8'(MOTOR_TRIP_COUNT))
              flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_MOTOR_OL, cfg.fatal_mask);
          end else if (motor_cnt_nxt != 8'(MOTOR_TRIP_COUNT) && motor_cnt_nxt != 8'd0) begin
            motor_cnt_nxt = motor_cnt_nxt - 8'd1;
          end
        end
        if (ch_r == pmu_pkg::CH_LOAD2 && act && !flags_nxt[6]) begin
          if (avg_r > cfg.overtemp_current) begin
            if (load2_cnt_nxt != 8'hFF) load2_cnt_nxt = load2_cnt_nxt + 8'd1;
            if (load2_cnt_nxt == 8'(LOAD_TRIP_COUNT))
              flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_LOAD2_OFF, cfg.fatal_mask);
          end else if (load2_cnt_nxt != 8'd0) begin
            load2_cnt_nxt = load2_cnt_nxt - 8'd1;
          end
        end
        if (ch_r == pmu_pkg::CH_LOAD1 && act && !flags_nxt[5]) begin
          if (avg_r > cfg.overtemp_current) begin
            if (load1_cnt_nxt != 8'hFF) load1_cnt_nxt = load1_cnt_nxt + 8'd1;
            if (load1_cnt_nxt == 8'(LOAD_TRIP_COUNT))
              flags_nxt = pmu_pkg::raise_flag(flags_nxt, pmu_pkg::F_LOAD1_OFF, cfg.fatal_mask);
          end else if (load1_cnt_nxt != 8'd0) begin
            load1_cnt_nxt = load1_cnt_nxt - 8'd1;
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      flags_r     <= '0;
      motor_cnt_r <= '0;
      load1_cnt_r <= '0;
      load2_cnt_r <= '0;
      for (int i = 0; i < pmu_pkg::NUM_SLOT; i++) begin
        sum_r[i]  <= '0;
        pos_r[i]  <= '0;
        fill_r[i] <= '0;
      end
      for (int i = 0; i < 4; i++) cur_avg_r[i] <= '0;
    end else begin
      if (out_valid_r && out_ready && !fire) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (q_valid) begin
            ch_r   <= q_data.channel;
            val_r  <= q_data.value;
            avg_r  <= q_data.value;
            slot_r <= q_slot;
            addr_r <= q_addr;
            if (q_data.channel == pmu_pkg::CH_TEMP || q_data.channel == pmu_pkg::CH_NONE)
              state_r <= S_FIN;
            else
              state_r <= S_UPD;
          end
        end
        S_UPD: begin
          sum_r[slot_r]  <= new_sum;
          pos_r[slot_r]  <= new_pos;
          fill_r[slot_r] <= new_fill;
          dvd_r <= new_sum;
          dvs_r <= new_fill;
          rem_r <= '0;
          cnt_r <= CNT_W'(SUM_W);
          state_r <= S_DIV;
        end
        S_DIV: begin
          // restoring division, one quotient bit per cycle
          if (trial >= {1'b0, dvs_r}) begin
            rem_r <= FILL_W'(trial - {1'b0, dvs_r});
            dvd_r <= {dvd_r[SUM_W-2:0], 1'b1};
          end else begin
            rem_r <= trial[FILL_W-1:0];
            dvd_r <= {dvd_r[SUM_W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == CNT_W'(1)) state_r <= S_FIN;
        end
        S_FIN: begin
          if (avg_load) begin
            avg_r <= dvd_r[pmu_pkg::VAL_W-1:0];
            cnt_r <= CNT_W'(SUM_W);
          end else if (fire) begin
            flags_r     <= flags_nxt;
            motor_cnt_r <= motor_cnt_nxt;
            load1_cnt_r <= load1_cnt_nxt;
            load2_cnt_r <= load2_cnt_nxt;
            if (ch_r >= pmu_pkg::CH_MOTOR && ch_r <= pmu_pkg::CH_LOAD1)
              cur_avg_r[slot_r[1:0] - 2'd2] <= avg_r;
            out_data_r  <= {7'd0, flags_nxt[7], flags_nxt, avg_r};
            out_valid_r <= 1'b1;
            state_r     <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_shutdown_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(flags_r[7]) |-> flags_r[7]) else $error("shutdown flag cleared");
  a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV |-> dvs_r != '0) else $error("divide by zero fill");
  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == S_IDLE) else $error("pop while busy");
  a_out_shut_copy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_data_r[24] == out_data_r[23]) else $error("shut_down mismatch");

endmodule
